// ----- design/text_console_char_writer_top_assert.svh -----
// Assertion macros shared by the console RTL.
// Defining ASSERT_OFF turns every check into empty text.
`ifndef TEXT_CONSOLE_CHAR_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define TCCW_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("console check failed");

`define TCCW_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("console check failed");

`define TCCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("console check failed");

`else

`define TCCW_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define TCCW_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define TCCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/tccw_pkg.sv -----
package tccw_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_SPACES = 4;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // Derived widths.
  localparam int CELL_AW = $clog2(CELL_COUNT);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int TAB_W   = $clog2(TAB_SPACES + 1);

  // Fixed field widths of the item channels.
  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int CURSOR_W = 11;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef logic [2*CHAR_W-1:0] cell_t;

  // Character codes with special handling.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [CHAR_W-1:0] ATTR_PLAIN = 8'h07;
  localparam cell_t             BLANK_CELL = {ATTR_PLAIN, CH_SPACE};

endpackage

// ----- design/tccw_if.sv -----
interface tccw_in_if;
  import tccw_pkg::*;

  logic                valid;
  logic                ready;
  op_t                 operation;
  logic [CHAR_W-1:0]   char_code;
  logic [INDEX_W-1:0]  cell_index;

  modport source (output valid, output operation, output char_code,
                  output cell_index, input ready);
  modport sink   (input valid, input operation, input char_code,
                  input cell_index, output ready);
endinterface

interface tccw_out_if;
  import tccw_pkg::*;

  logic                valid;
  logic                ready;
  logic [CURSOR_W-1:0] cursor_position;
  logic [CHAR_W-1:0]   read_char;
  logic [CHAR_W-1:0]   read_attribute;

  modport source (output valid, output cursor_position, output read_char,
                  output read_attribute, input ready);
  modport sink   (input valid, input cursor_position, input read_char,
                  input read_attribute, output ready);
endinterface

// ----- design/text_console_char_writer_top.sv -----
// A read passes S_READ, a plain character S_PUT, before S_DONE; a cursor move goes straight to S_DONE;
// a tab writes TAB_SPACES blanks in S_PUT, and any scroll adds the S_SCROLL copy and S_BLANK sweep.
// Items are taken one at a time; the next item is taken once the result is in the output register.
// A clear item blanks all CELL_COUNT cells (2000) before its result is handed over.
// Reset (rst_n low, synchronous) zeroes the cursor and starts a sweep that blanks every cell of
// the screen memory; no item is accepted until the sweep ends.
`include "text_console_char_writer_top_assert.svh"

module text_console_char_writer_top (
  input  logic       clk,
  input  logic       rst_n,
  tccw_in_if.sink    in_ch,
  tccw_out_if.source out_ch
);
  import tccw_pkg::*;

  // The controller walks these states. Every memory sweep (reset blanking, clear, scroll copy,
  // bottom row blanking) runs off the shared counter cnt_r.
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PUT    = 7'b0000010,
    S_SCROLL = 7'b0000100,
    S_BLANK  = 7'b0001000,
    S_CLEAR  = 7'b0010000,
    S_READ   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  localparam logic [CELL_AW-1:0] LAST_CELL   = CELL_AW'(CELL_COUNT - 1);
  localparam logic [CELL_AW-1:0] SCROLL_LAST = CELL_AW'(CELL_COUNT - COLUMNS);
  localparam logic [CELL_AW-1:0] COL_STEP    = CELL_AW'(COLUMNS);
  localparam logic [ROW_W-1:0]   LAST_ROW    = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]   LAST_COL    = COL_W'(COLUMNS - 1);

  // Screen memory: one write port and one registered read port.
  cell_t              mem [CELL_COUNT];
  cell_t              rd_data_r;
  logic [CELL_AW-1:0] rd_addr;
  logic               mem_we;
  logic [CELL_AW-1:0] mem_wa;
  cell_t              mem_wd;

  state_t             state_r, state_nxt;
  logic [CELL_AW-1:0] cursor_r, cursor_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [CELL_AW-1:0] cnt_r, cnt_nxt;
  logic [TAB_W-1:0]   put_cnt_r, put_cnt_nxt;
  logic [CHAR_W-1:0]  put_char_r, put_char_nxt;
  logic               item_r, item_nxt;
  logic               oob_r, oob_nxt;
  logic [CHAR_W-1:0]  res_char_r, res_char_nxt;
  logic [CHAR_W-1:0]  res_attr_r, res_attr_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [CURSOR_W-1:0] out_cursor_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic [CHAR_W-1:0]   out_attr_r;

  logic in_fire;
  logic out_load;
  logic idx_in_range;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign idx_in_range = (in_ch.cell_index < INDEX_W'(CELL_COUNT));

  assign out_ch.valid           = out_valid_r;
  assign out_ch.cursor_position = out_cursor_r;
  assign out_ch.read_char       = out_char_r;
  assign out_ch.read_attribute  = out_attr_r;

  // Read address: the requested cell while idle, the source row during a scroll copy.
  always_comb begin
    rd_addr = '0;
    if (state_r == S_IDLE) begin
      if (idx_in_range) begin
        rd_addr = CELL_AW'(in_ch.cell_index);
      end
    end else if (state_r == S_SCROLL) begin
      if (cnt_r < SCROLL_LAST) begin
        rd_addr = cnt_r + COL_STEP;
      end
    end
  end

  // Write port. During a scroll the cell read in the last cycle lands one row higher.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_r;
    mem_wd = BLANK_CELL;
    case (state_r)
      S_CLEAR, S_BLANK: begin
        mem_we = 1'b1;
      end
      S_PUT: begin
        mem_we = 1'b1;
        mem_wa = cursor_r;
        mem_wd = {ATTR_PLAIN, put_char_r};
      end
      S_SCROLL: begin
        mem_we = (cnt_r != '0);
        mem_wa = cnt_r - CELL_AW'(1);
        mem_wd = rd_data_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt    = state_r;
    cursor_nxt   = cursor_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    cnt_nxt      = cnt_r;
    put_cnt_nxt  = put_cnt_r;
    put_char_nxt = put_char_r;
    item_nxt     = item_r;
    oob_nxt      = oob_r;
    res_char_nxt = res_char_r;
    res_attr_nxt = res_attr_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_char_nxt = '0;
          res_attr_nxt = '0;
          case (in_ch.operation)
            OP_WRITE: begin
              case (in_ch.char_code)
                CH_TAB: begin
                  put_char_nxt = CH_SPACE;
                  put_cnt_nxt  = TAB_W'(TAB_SPACES);
                  state_nxt    = S_PUT;
                end
                CH_CR: begin
                  cursor_nxt = cursor_r - CELL_AW'(col_r);
                  col_nxt    = '0;
                  state_nxt  = S_DONE;
                end
                CH_FF, CH_LF: begin
                  // Newline also returns to column 0; form feed keeps the column.
                  if (in_ch.char_code == CH_LF) begin
                    cursor_nxt = cursor_r - CELL_AW'(col_r);
                    col_nxt    = '0;
                  end
                  if (row_r == LAST_ROW) begin
                    // The cursor stays on the bottom row while the text moves up.
                    put_cnt_nxt = '0;
                    cnt_nxt     = '0;
                    state_nxt   = S_SCROLL;
                  end else begin
                    cursor_nxt = cursor_nxt + COL_STEP;
                    row_nxt    = row_r + ROW_W'(1);
                    state_nxt  = S_DONE;
                  end
                end
                CH_NUL: begin
                  put_char_nxt = CH_SPACE;
                  put_cnt_nxt  = TAB_W'(1);
                  state_nxt    = S_PUT;
                end
                default: begin
                  put_char_nxt = in_ch.char_code;
                  put_cnt_nxt  = TAB_W'(1);
                  state_nxt    = S_PUT;
                end
              endcase
            end
            OP_READ: begin
              oob_nxt   = !idx_in_range;
              state_nxt = S_READ;
            end
            OP_CLEAR: begin
              cnt_nxt   = '0;
              item_nxt  = 1'b1;
              state_nxt = S_CLEAR;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_PUT: begin
        // The cell is written this cycle; the cursor advances and may wrap into a scroll.
        put_cnt_nxt = put_cnt_r - TAB_W'(1);
        if (col_r == LAST_COL) begin
          col_nxt = '0;
          if (row_r == LAST_ROW) begin
            cursor_nxt = SCROLL_LAST;
            cnt_nxt    = '0;
            state_nxt  = S_SCROLL;
          end else begin
            row_nxt    = row_r + ROW_W'(1);
            cursor_nxt = cursor_r + CELL_AW'(1);
            state_nxt  = (put_cnt_r == TAB_W'(1)) ? S_DONE : S_PUT;
          end
        end else begin
          col_nxt    = col_r + COL_W'(1);
          cursor_nxt = cursor_r + CELL_AW'(1);
          state_nxt  = (put_cnt_r == TAB_W'(1)) ? S_DONE : S_PUT;
        end
      end

      S_SCROLL: begin
        if (cnt_r == SCROLL_LAST) begin
          state_nxt = S_BLANK;
        end else begin
          cnt_nxt = cnt_r + CELL_AW'(1);
        end
      end

      S_BLANK: begin
        if (cnt_r == LAST_CELL) begin
          state_nxt = (put_cnt_r != '0) ? S_PUT : S_DONE;
        end else begin
          cnt_nxt = cnt_r + CELL_AW'(1);
        end
      end

      S_CLEAR: begin
        if (cnt_r == LAST_CELL) begin
          // The sweep after reset carries no item and gives no result.
          state_nxt = item_r ? S_DONE : S_IDLE;
          item_nxt  = 1'b0;
        end else begin
          cnt_nxt = cnt_r + CELL_AW'(1);
        end
      end

      S_READ: begin
        if (!oob_r) begin
          res_char_nxt = rd_data_r[CHAR_W-1:0];
          res_attr_nxt = rd_data_r[2*CHAR_W-1:CHAR_W];
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cursor_r    <= '0;
      row_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      put_cnt_r   <= '0;
      item_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      put_cnt_r   <= put_cnt_nxt;
      item_r      <= item_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    put_char_r <= put_char_nxt;
    oob_r      <= oob_nxt;
    res_char_r <= res_char_nxt;
    res_attr_r <= res_attr_nxt;
    if (out_load) begin
      out_cursor_r <= CURSOR_W'(cursor_r);
      out_char_r   <= res_char_r;
      out_attr_r   <= res_attr_r;
    end
  end

  // The cursor always points inside the screen and agrees with its row and column.
  `TCCW_ASSERT_ALWAYS(a_cursor_in_screen, clk, rst_n, cursor_r < CELL_AW'(CELL_COUNT))
  `TCCW_ASSERT_ALWAYS(a_cursor_row_col, clk, rst_n, (cursor_r == CELL_AW'(row_r * COLUMNS + col_r)) && (col_r <= LAST_COL))
  // Nothing writes the screen while the block waits for an item.
  `TCCW_ASSERT_IMPLIES(a_idle_no_write, clk, rst_n, state_r == S_IDLE, !mem_we)
  // The scroll copy never reads and writes the same cell in one cycle.
  `TCCW_ASSERT_IMPLIES(a_scroll_no_clash, clk, rst_n, (state_r == S_SCROLL) && mem_we, mem_wa != rd_addr)
  // A read item moves from S_READ to S_DONE in the next cycle; the handover may then wait on out_ch.ready.
  `TCCW_ASSERT_NEXT(a_read_to_done, clk, rst_n, state_r == S_READ, state_r == S_DONE)

endmodule
